FILE: rtl/gcs_pkg.sv
// Shared types and constants for the graph coloring search core.
package gcs_pkg;

    // Default number of vertices that the core provides storage for.
    localparam int MAX_VERTICES_DEF = 8;

    // Field widths of the request and result items.
    localparam int CMD_W       = 1;
    localparam int ROW_INDEX_W = 3;
    localparam int ROW_BITS_W  = 8;
    localparam int VERTEX_W    = 3;
    localparam int COLOR_W     = 4;
    localparam int CFG_W       = 4;
    localparam int CFG_ADDR_W  = 1;

    // Packed data widths on the two stream channels.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // One bit per possible color value.
    localparam int NUM_COLOR_CODES = 1 << COLOR_W;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLORS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 1'b1;

    // Register reset values.
    localparam logic [CFG_W-1:0] NUM_COLORS_RST   = 4'd3;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 4'd4;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SOLVE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_ADJ,
        ST_SCAN,
        ST_PICK,
        ST_BACK,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_FAIL
    } state_t;

endpackage

FILE: rtl/gcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/graph_coloring_search_core.sv
// Backtracking graph m-coloring search core.
//
// Requests arrive on the s_ stream channel. A load request (cmd 0) writes
// one adjacency row into the adjacency RAM. A solve request (cmd 1) runs a
// depth-first search for the lexicographically first coloring with colors
// 1..num_colors over vertices 0..vertex_count-1, the count clamped to 1..DEPTH.
// Results leave on the m_ channel: one per vertex with m_tlast on the final
// one, or a single not-found result (found 0, vertex 0, color 0, last).
// Configuration is written through cfg_wr_en/cfg_wr_addr/cfg_wr_data while
// the core is idle; it takes effect at the next solve.
// In each forward or retry step at vertex v, the adjacency row is read,
// then the colors of vertices below v are read from the color RAM one per
// cycle to build the set of blocked colors. A backtrack first fetches the
// previous vertex's color in ST_BACK. Results then stream out, each one
// paced by a color RAM read in ST_OUT_RD before ST_OUT_LD. Total time per solve
// depends on the graph and grows exponentially in the worst case.
// Only one request is in work at a time; s_tready is high only while idle.
// A stalled m_tready holds the result register and the output step waits.
// After reset the adjacency rows read as zero and the registers hold their
// reset values; there is no clearing pass.
module graph_coloring_search_core #(
    parameter int MAX_VERTICES = gcs_pkg::MAX_VERTICES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: cmd, row_index, row_bits, zero padding.
    input  logic [gcs_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: found, vertex, color.
    output logic [gcs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [gcs_pkg::CFG_ADDR_W-1:0]  cfg_wr_addr,
    input  logic [gcs_pkg::CFG_W-1:0]       cfg_wr_data
);

    // Row indexes are three bits wide, so at most eight rows are ever used.
    localparam int DEPTH = (MAX_VERTICES < 8) ? MAX_VERTICES : 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = gcs_pkg::COLOR_W;
    localparam int NCC   = gcs_pkg::NUM_COLOR_CODES;

    gcs_pkg::state_t state_reg, state_next;

    logic [CW-1:0]    num_colors_reg, num_colors_next;
    logic [CW-1:0]    vertex_count_reg, vertex_count_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [AW-1:0]    v_reg, v_next;
    logic [AW-1:0]    i_reg, i_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic             pend_reg, pend_next;
    logic [CW-1:0]    cur_reg, cur_next;
    logic [NCC-1:0]   mask_reg, mask_next;
    logic [gcs_pkg::ROW_BITS_W-1:0] adj_row_reg, adj_row_next;
    logic [DEPTH-1:0] row_valid_reg, row_valid_next;
    logic [AW-1:0]    o_reg, o_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [gcs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;

    // Request fields.
    logic [gcs_pkg::CMD_W-1:0]       in_cmd;
    logic [gcs_pkg::ROW_INDEX_W-1:0] in_row_index;
    logic [gcs_pkg::ROW_BITS_W-1:0]  in_row_bits;

    // RAM ports.
    logic                           adj_wr_en;
    logic [AW-1:0]                  adj_wr_addr;
    logic                           adj_rd_en;
    logic [gcs_pkg::ROW_BITS_W-1:0] adj_rd_data;
    logic                           col_wr_en;
    logic [CW-1:0]                  col_wr_data;
    logic                           col_rd_en;
    logic [AW-1:0]                  col_rd_addr;
    logic [CW-1:0]                  col_rd_data;

    // Color choice.
    logic [NCC-1:0] cand;
    logic           pick_ok;
    logic [CW-1:0]  pick_color;
    logic           out_free;
    logic [CW-1:0]  n_eff;

    assign in_cmd       = s_tdata[0];
    assign in_row_index = s_tdata[3:1];
    assign in_row_bits  = s_tdata[11:4];

    assign s_tready = (state_reg == gcs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Clamp the vertex count to the range the storage supports.
    always_comb begin
        priority if (vertex_count_reg == '0) begin
            n_eff = CW'(1);
        end else if (vertex_count_reg > CW'(DEPTH)) begin
            n_eff = CW'(DEPTH);
        end else begin
            n_eff = vertex_count_reg;
        end
    end

    // Colors above the current one, within range, not used by a neighbor.
    always_comb begin
        for (int c = 0; c < NCC; c++) begin
            cand[c] = (c != 0) && !mask_reg[c] && (CW'(c) > cur_reg)
                      && (CW'(c) <= num_colors_reg);
        end
        pick_ok    = |cand;
        pick_color = '0;
        for (int c = NCC - 1; c > 0; c--) begin
            if (cand[c]) begin
                pick_color = CW'(c);
            end
        end
    end

    gcs_ram #(
        .WIDTH (gcs_pkg::ROW_BITS_W),
        .DEPTH (DEPTH)
    ) u_adj_ram (
        .aclk    (aclk),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (in_row_bits),
        .rd_en   (adj_rd_en),
        .rd_addr (v_reg),
        .rd_data (adj_rd_data)
    );

    gcs_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_color_ram (
        .aclk    (aclk),
        .wr_en   (col_wr_en),
        .wr_addr (v_reg),
        .wr_data (col_wr_data),
        .rd_en   (col_rd_en),
        .rd_addr (col_rd_addr),
        .rd_data (col_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= gcs_pkg::ST_IDLE;
            num_colors_reg   <= gcs_pkg::NUM_COLORS_RST;
            vertex_count_reg <= gcs_pkg::VERTEX_COUNT_RST;
            row_valid_reg    <= '0;
            pend_reg         <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            num_colors_reg   <= num_colors_next;
            vertex_count_reg <= vertex_count_next;
            row_valid_reg    <= row_valid_next;
            pend_reg         <= pend_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        v_reg        <= v_next;
        i_reg        <= i_next;
        pend_idx_reg <= pend_idx_next;
        cur_reg      <= cur_next;
        mask_reg     <= mask_next;
        adj_row_reg  <= adj_row_next;
        o_reg        <= o_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    always_comb begin
        state_next        = state_reg;
        num_colors_next   = num_colors_reg;
        vertex_count_next = vertex_count_reg;
        n_next            = n_reg;
        v_next            = v_reg;
        i_next            = i_reg;
        pend_idx_next     = pend_idx_reg;
        pend_next         = 1'b0;
        cur_next          = cur_reg;
        mask_next         = mask_reg;
        adj_row_next      = adj_row_reg;
        row_valid_next    = row_valid_reg;
        o_next            = o_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tlast_next      = m_tlast_reg;
        adj_wr_en         = 1'b0;
        adj_wr_addr       = AW'(in_row_index);
        adj_rd_en         = 1'b0;
        col_wr_en         = 1'b0;
        col_wr_data       = '0;
        col_rd_en         = 1'b0;
        col_rd_addr       = i_reg;

        if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                gcs_pkg::REG_NUM_COLORS:   num_colors_next   = cfg_wr_data;
                gcs_pkg::REG_VERTEX_COUNT: vertex_count_next = cfg_wr_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            gcs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_cmd == gcs_pkg::CMD_SOLVE) begin
                        n_next     = n_eff;
                        v_next     = '0;
                        cur_next   = '0;
                        state_next = gcs_pkg::ST_ROW;
                    end else if (4'(in_row_index) < 4'(DEPTH)) begin
                        adj_wr_en = 1'b1;
                        row_valid_next[AW'(in_row_index)] = 1'b1;
                    end
                end
            end
            gcs_pkg::ST_ROW: begin
                adj_rd_en  = 1'b1;
                i_next     = '0;
                mask_next  = '0;
                state_next = gcs_pkg::ST_ADJ;
            end
            gcs_pkg::ST_ADJ: begin
                // Rows never loaded since reset read as no neighbors.
                adj_row_next = row_valid_reg[v_reg] ? adj_rd_data : '0;
                state_next   = gcs_pkg::ST_SCAN;
            end
            gcs_pkg::ST_SCAN: begin
                // Only vertices below v hold colors; the rest are uncolored.
                if (pend_reg && adj_row_reg[pend_idx_reg]) begin
                    mask_next = mask_reg | (NCC'(1) << col_rd_data);
                end
                if (i_reg < v_reg) begin
                    col_rd_en     = 1'b1;
                    col_rd_addr   = i_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = i_reg;
                    i_next        = i_reg + AW'(1);
                end else begin
                    state_next = gcs_pkg::ST_PICK;
                end
            end
            gcs_pkg::ST_PICK: begin
                col_wr_en = 1'b1;
                if (pick_ok) begin
                    col_wr_data = pick_color;
                    if (CW'(v_reg) + CW'(1) >= n_reg) begin
                        o_next     = '0;
                        state_next = gcs_pkg::ST_OUT_RD;
                    end else begin
                        v_next     = v_reg + AW'(1);
                        cur_next   = '0;
                        state_next = gcs_pkg::ST_ROW;
                    end
                end else begin
                    col_wr_data = '0;
                    if (v_reg == '0) begin
                        state_next = gcs_pkg::ST_FAIL;
                    end else begin
                        col_rd_en   = 1'b1;
                        col_rd_addr = v_reg - AW'(1);
                        v_next      = v_reg - AW'(1);
                        state_next  = gcs_pkg::ST_BACK;
                    end
                end
            end
            gcs_pkg::ST_BACK: begin
                cur_next   = col_rd_data;
                state_next = gcs_pkg::ST_ROW;
            end
            gcs_pkg::ST_OUT_RD: begin
                col_rd_en   = 1'b1;
                col_rd_addr = o_reg;
                state_next  = gcs_pkg::ST_OUT_LD;
            end
            gcs_pkg::ST_OUT_LD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {col_rd_data, gcs_pkg::VERTEX_W'(o_reg), 1'b1};
                    m_tlast_next  = (CW'(o_reg) + CW'(1) == n_reg);
                    if (CW'(o_reg) + CW'(1) == n_reg) begin
                        state_next = gcs_pkg::ST_IDLE;
                    end else begin
                        o_next     = o_reg + AW'(1);
                        state_next = gcs_pkg::ST_OUT_RD;
                    end
                end
            end
            gcs_pkg::ST_FAIL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    state_next    = gcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/gcs_checker.sv
// Port-level checks for the graph coloring search core, bound to the top level.
module gcs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gcs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // The result register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A not-found result is a lone, all-zero, final result.
    a_not_found_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tlast && (m_tdata[7:1] == '0))
        else $error("malformed not-found result");

    // A found result always carries a real color.
    a_found_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[7:4] != '0))
        else $error("found result with color zero");

    // No new request is taken while a run still has results to send.
    a_busy_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a result run");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind graph_coloring_search_core gcs_checker u_gcs_checker (.*);

FILE: tb/sv/gcs_coloring_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the coloring results of the search core and compares them.
module gcs_coloring_checker
    import gcs_pkg::*;
#(
    parameter int MAX_V = MAX_VERTICES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // s_tdata from bit 0: cmd, row_index, row_bits, zero padding.
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata from bit 0: found, vertex, color.
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_wr_addr,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    output int                     fail_count,
    output int                     results_pending
);

    localparam int VTX_CAP   = (MAX_V > 8) ? 8 : MAX_V;
    localparam int ROW_LSB   = CMD_W;
    localparam int BITS_LSB  = CMD_W + ROW_INDEX_W;
    localparam int VTX_LSB   = 1;
    localparam int COLOR_LSB = 1 + VERTEX_W;

    typedef struct packed {
        logic                found;
        logic [VERTEX_W-1:0] vertex;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } coloring_rpt_t;

    logic [ROW_BITS_W-1:0] adj_rows [MAX_V];
    logic [COLOR_W-1:0]    hue      [MAX_V];
    logic [3:0]            search_pos;
    logic [CFG_W-1:0]      colors_allowed;
    logic [CFG_W-1:0]      vertices_used;
    coloring_rpt_t         coloring_q [$];
    int                    errs = 0;

    // A vertex count of zero means one; anything above the storage is clipped.
    function automatic int vertex_span();
        if (vertices_used == 0) return 1;
        if (vertices_used > VTX_CAP) return VTX_CAP;
        return vertices_used;
    endfunction

    function automatic bit hue_fits(int v, int c, int n);
        for (int i = 0; i < n; i++) begin
            if (adj_rows[v][i] && hue[i] == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Depth-first search in lexicographic order. Uncolored vertices hold zero,
    // which never clashes, so self loops and rows above v do no harm.
    function automatic bit find_coloring(int n);
        int k;
        int v;
        int c;
        bit placed;
        k = colors_allowed;
        v = 0;
        foreach (hue[i]) hue[i] = '0;
        while (1'b1) begin
            c = hue[v] + 1;
            placed = 1'b0;
            hue[v] = '0;
            while (!placed && c <= k) begin
                if (hue_fits(v, c, n)) begin
                    hue[v] = c[COLOR_W-1:0];
                    placed = 1'b1;
                end else begin
                    c++;
                end
            end
            if (placed) begin
                v++;
                if (v >= n) begin
                    search_pos = v[3:0];
                    return 1'b1;
                end
            end else begin
                if (v == 0) begin
                    search_pos = '0;
                    return 1'b0;
                end
                v--;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_solve();
        int n;
        coloring_rpt_t r;
        n = vertex_span();
        if (!find_coloring(n)) begin
            r.found  = 1'b0;
            r.vertex = '0;
            r.color  = '0;
            r.last   = 1'b1;
            coloring_q.push_back(r);
        end else begin
            for (int v = 0; v < n; v++) begin
                r.found  = 1'b1;
                r.vertex = v[VERTEX_W-1:0];
                r.color  = hue[v];
                r.last   = (v + 1 == n);
                coloring_q.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        coloring_rpt_t got;
        coloring_rpt_t want;
        if (!aresetn) begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
            foreach (hue[i]) hue[i] = '0;
            search_pos     = '0;
            colors_allowed = NUM_COLORS_RST;
            vertices_used  = VERTEX_COUNT_RST;
            coloring_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_addr == REG_NUM_COLORS) begin
                    colors_allowed = cfg_wr_data;
                end else if (cfg_wr_addr == REG_VERTEX_COUNT) begin
                    vertices_used = cfg_wr_data;
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tdata[CMD_W-1:0] == CMD_SOLVE) begin
                    predict_solve();
                end else if (s_tdata[ROW_LSB +: ROW_INDEX_W] < MAX_V) begin
                    adj_rows[s_tdata[ROW_LSB +: ROW_INDEX_W]] = s_tdata[BITS_LSB +: ROW_BITS_W];
                end
            end
            if (m_tvalid && m_tready) begin
                got.found  = m_tdata[0];
                got.vertex = m_tdata[VTX_LSB +: VERTEX_W];
                got.color  = m_tdata[COLOR_LSB +: COLOR_W];
                got.last   = m_tlast;
                if (coloring_q.size() == 0) begin
                    $error("unexpected result: found %0d vertex %0d color %0d last %0d",
                           got.found, got.vertex, got.color, got.last);
                    errs++;
                end else begin
                    want = coloring_q.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("vertex", want.vertex, got.vertex);
                    check_field("color", want.color, got.color);
                    check_field("last", want.last, got.last);
                end
            end
        end
        fail_count      <= errs + ((aresetn) ? 0 : 0);
        results_pending <= coloring_q.size();
    end

    // Results still owed when the run ends are failures too; the top waits
    // for this count to reach zero, so a leftover shows up as a timeout.

endmodule

FILE: tb/sv/tb_graph_coloring_search_core.sv
`timescale 1ns / 100ps
// Top of the graph coloring search core testbench: clock, reset, stimulus and verdict.
module tb_graph_coloring_search_core;
    import gcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 400_000;
    localparam int RANDOM_ITEMS   = 150;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_wr_addr = '0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;
    logic                  idle_on     = 1'b1;
    int                    fail_count;
    int                    results_pending;
    int                    random_items = 0;

    graph_coloring_search_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    gcs_coloring_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_addr     (cfg_wr_addr),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= (idle_on && ($urandom_range(0, 99) < 26)) ? 1'b0 : 1'b1;
    end

    // The quiet-cycle count restarts on every accepted request or result.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Returns at the edge where the request is accepted, so the next request
    // can follow back to back without dropping s_tvalid.
    task automatic send_req(input logic [CMD_W-1:0] cmd,
                            input logic [ROW_INDEX_W-1:0] row,
                            input logic [ROW_BITS_W-1:0] bits);
        while (idle_on && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - CMD_W - ROW_INDEX_W - ROW_BITS_W){1'b0}}, bits, row, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds off new requests until every predicted result has been taken,
    // then lets the core settle back to idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] colors, input logic [CFG_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= REG_NUM_COLORS;
        cfg_wr_data <= colors;
        @(posedge aclk);
        cfg_wr_addr <= REG_VERTEX_COUNT;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int phase;
        int n_reg;
        int k_reg;
        int eff_n;
        int density;
        logic [ROW_BITS_W-1:0] bits;
        phase = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers, empty graph; the solve request carries junk fields.
        send_req(CMD_SOLVE, 3'd7, 8'hFF);
        // Complete graph on four vertices with self loops and bits beyond the count.
        for (int v = 0; v < 4; v++) send_req(CMD_LOAD, v[2:0], 8'hFF);
        send_req(CMD_SOLVE, 3'd0, 8'h00);
        drain();
        set_config(4'd4, 4'd4);
        send_req(CMD_SOLVE, 3'd5, 8'hA5);
        drain();
        // No colors at all, and a vertex count of zero.
        set_config(4'd0, 4'd0);
        send_req(CMD_SOLVE, 3'd0, 8'h00);
        drain();
        set_config(4'd15, 4'd15);
        send_req(CMD_LOAD, 3'd4, 8'h00);
        // Row five points at vertex zero only, while row zero (all ones) points back.
        send_req(CMD_LOAD, 3'd5, 8'h01);
        send_req(CMD_LOAD, 3'd6, 8'hFF);
        send_req(CMD_LOAD, 3'd7, 8'h80);
        send_req(CMD_SOLVE, 3'd2, 8'h5A);
        drain();
        set_config(4'd2, 4'd8);
        send_req(CMD_SOLVE, 3'd1, 8'h00);
        drain();
        set_config(4'd1, 4'd1);
        send_req(CMD_SOLVE, 3'd0, 8'h00);
        drain();
        set_config(4'd8, 4'd8);
        send_req(CMD_LOAD, 3'd0, 8'h00);
        send_req(CMD_SOLVE, 3'd4, 8'h3C);

        while (random_items < RANDOM_ITEMS) begin
            phase++;
            idle_on <= !(phase == 3 || phase == 4);
            drain();
            n_reg = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 15);
            eff_n = (n_reg == 0) ? 1 : ((n_reg > 8) ? 8 : n_reg);
            // Large graphs only get few colors or plenty, which keeps the
            // backtracking depth bounded.
            if (eff_n >= 7) begin
                case ($urandom_range(0, 2))
                    0:       k_reg = $urandom_range(0, 3);
                    1:       k_reg = 3;
                    default: k_reg = $urandom_range(8, 15);
                endcase
            end else begin
                k_reg = $urandom_range(0, 15);
            end
            set_config(k_reg[CFG_W-1:0], n_reg[CFG_W-1:0]);
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 4) != 0) begin
                    density = $urandom_range(10, 90);
                    for (int v = 0; v < eff_n; v++) begin
                        bits = '0;
                        for (int i = 0; i < ROW_BITS_W; i++) begin
                            bits[i] = ($urandom_range(0, 99) < density);
                        end
                        send_req(CMD_LOAD, v[2:0], bits);
                        random_items++;
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_req(CMD_LOAD, ROW_INDEX_W'($urandom_range(0, 7)),
                                 ROW_BITS_W'($urandom_range(0, 255)));
                        random_items++;
                    end
                end
                send_req(CMD_SOLVE, ROW_INDEX_W'($urandom_range(0, 7)),
                         ROW_BITS_W'($urandom_range(0, 255)));
                random_items++;
            end
        end

        drain();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
